FILE: hdl/slpc_pkg.sv
package slpc_pkg;

  // pulse width classes
  localparam logic [15:0] SYNC_MIN   = 16'd2750;
  localparam logic [15:0] DROP_ABOVE = 16'd6750;
  localparam int          CODE_STEP  = 500;
  localparam int          CODE_MAX   = 8;

  // configuration register indexes
  localparam logic [1:0] REG_CLUSTER_WINDOW = 2'd0;
  localparam logic [1:0] REG_SECOND_WINDOW  = 2'd1;
  localparam logic [1:0] REG_RESYNC_GAP     = 2'd2;

  // configuration reset values
  localparam logic [19:0] CLUSTER_WINDOW_RST = 20'd2400;
  localparam logic [19:0] SECOND_WINDOW_RST  = 20'd24000;
  localparam logic [26:0] RESYNC_GAP_RST     = 27'd370000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP_CMP,
    ST_SCAN,
    ST_SCAN_EMIT,
    ST_TRACK
  } state_t;

  // one entry of the per-sensor hit store
  typedef struct packed {
    logic [11:0] width;
    logic [31:0] stamp;
  } hit_entry_t;

  // sync code: (width - 2750) / 500 by threshold compares, width in 2751..6750
  function automatic logic [3:0] sync_code(input logic [15:0] w);
    logic [12:0] d;
    logic [3:0]  c;
    d = 13'(w - SYNC_MIN);
    c = '0;
    for (int k = 1; k <= CODE_MAX; k++) begin
      if (d >= 13'(k * CODE_STEP)) c = c + 4'd1;
    end
    return c;
  endfunction

endpackage

FILE: hdl/slpc_if.sv
interface slpc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] capture_time;
  logic [7:0]  sensor_index;
  logic [15:0] pulse_width;

  modport source (output valid, capture_time, sensor_index, pulse_width, input ready);
  modport sink (input valid, capture_time, sensor_index, pulse_width, output ready);
endinterface

interface slpc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  emitter;
  logic        axis;
  logic [31:0] sweep_start;
  logic [7:0]  hit_sensor;
  logic [31:0] hit_offset;
  logic [11:0] hit_width;
  logic        data_bit;
  logic [31:0] sync_time;
  logic        last;

  modport source (output valid, kind, emitter, axis, sweep_start, hit_sensor, hit_offset,
                  hit_width, data_bit, sync_time, last, input ready);
  modport sink (input valid, kind, emitter, axis, sweep_start, hit_sensor, hit_offset,
                hit_width, data_bit, sync_time, last, output ready);
endinterface

FILE: hdl/slpc_ram.sv
module slpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/sweep_light_pulse_classifier_core.sv
// Sweep light pulse classifier.
// pulse: one beat per light pulse capture (time, sensor, width). Pulses from
//   sensors at or above SENSOR_COUNT or wider than 6750 ticks are dropped;
//   wider than 2750 is a sync pulse, any other is a sweep hit.
// result: sweep hit beats (kind 0) for every stored sensor hit, in sensor
//   order, then one data bit beat (kind 1, last set) per sync pulse.
// cfg_*: register writes, to be issued only while no pulse is in flight.
// One item at a time. A dropped pulse, or a sweep pulse with no active
// emitter, goes through accept and decode only; a stored sweep pulse goes
// through accept, decode and a store read-modify-write. A sync pulse scans
// the hit store one entry a cycle while no hit beat waits on the receiver;
// each stored hit adds a state for its memory read before its beat is
// loaded, and the data bit beat follows the last entry.
// The output register lets a new pulse be taken while a result beat waits;
// a stalled receiver freezes the scan of a sync pulse until the beat is taken.
// Reset (synchronous) empties the hit store through its valid bits, marks
// all emitter codes invalid and loads the register defaults.
module sweep_light_pulse_classifier_core #(
  parameter int SENSOR_COUNT  = 32,
  parameter int EMITTER_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst,
  slpc_in_if.sink     pulse,
  slpc_out_if.source  result,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_wdata
);
  import slpc_pkg::*;

  localparam int SW  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int EIW = $clog2(EMITTER_COUNT);
  localparam logic [SW-1:0] IDX_LAST = SW'(SENSOR_COUNT - 1);

  state_t state, state_next;

  // configuration
  logic [19:0] cluster_window;
  logic [19:0] second_emitter_window;
  logic [26:0] resync_gap;

  // captured item and decode results
  logic [31:0]        item_time;
  logic [7:0]         item_sensor;
  logic [15:0]        item_width;
  logic [3:0]         code;
  logic signed [31:0] gap;
  logic [SW-1:0]      item_addr;

  // sync tracking
  logic [31:0]    last_sync_time;
  logic [EIW-1:0] current_emitter;
  logic [12:0]    emitter_max_width [EMITTER_COUNT];
  logic [31:0]    emitter_start_time [EMITTER_COUNT];
  logic [3:0]     emitter_code [EMITTER_COUNT];
  logic [EMITTER_COUNT-1:0] code_valid;
  logic           active_valid;
  logic [EIW-1:0] active_idx;
  logic [31:0]    active_start;
  logic [3:0]     active_code;

  // hit store
  logic [SENSOR_COUNT-1:0] hit_valid;
  logic [SW-1:0]  idx;
  logic           ram_rd_en;
  logic [SW-1:0]  ram_rd_addr;
  logic           ram_wr_en;
  hit_entry_t     ram_wr_data;
  hit_entry_t     ram_rd_data;

  // output register
  logic out_valid;
  logic slot_free;
  logic load_hit;
  logic load_bit;
  logic idx_inc;
  logic idx_clr;
  logic active_load;

  // decode helpers
  logic           drop;
  logic           is_sync;
  logic           act_found;
  logic [EIW-1:0] act_idx;
  logic [31:0]    act_start;
  logic [3:0]     act_code;
  logic           trk_join;
  logic           trk_second;
  logic           trk_resync;
  logic [EIW-1:0] cur_after;

  assign item_addr = item_sensor[SW-1:0];
  assign slot_free = !out_valid || result.ready;
  assign pulse.ready = (state == ST_IDLE) && !rst;
  assign result.valid = out_valid;

  assign drop    = (item_sensor >= 8'(SENSOR_COUNT)) || (item_width > DROP_ABOVE);
  assign is_sync = item_width > SYNC_MIN;

  slpc_ram #(
    .WIDTH ($bits(hit_entry_t)),
    .DEPTH (SENSOR_COUNT)
  ) u_hit_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (item_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign ram_wr_data = '{width: item_width[11:0], stamp: item_time};

  // active emitter: highest-numbered emitter with a valid code and skip bit clear
  always_comb begin
    act_found = 1'b0;
    act_idx   = '0;
    act_start = '0;
    act_code  = '0;
    for (int e = 0; e < EMITTER_COUNT; e++) begin
      if (code_valid[e] && !emitter_code[e][2]) begin
        act_found = 1'b1;
        act_idx   = EIW'(e);
        act_start = emitter_start_time[e];
        act_code  = emitter_code[e];
      end
    end
  end

  // sync gap classification
  always_comb begin
    trk_join   = gap < $signed({12'd0, cluster_window});
    trk_second = !trk_join && (gap < $signed({12'd0, second_emitter_window}));
    trk_resync = !trk_join && !trk_second && (gap > $signed({5'd0, resync_gap}));
    if (trk_second) cur_after = EIW'(1);
    else if (trk_resync) cur_after = '0;
    else cur_after = current_emitter;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and control
  always_comb begin
    state_next  = state;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx;
    ram_wr_en   = 1'b0;
    load_hit    = 1'b0;
    load_bit    = 1'b0;
    idx_inc     = 1'b0;
    idx_clr     = 1'b0;
    active_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pulse.valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (drop) begin
          state_next = ST_IDLE;
        end else if (is_sync) begin
          idx_clr    = 1'b1;
          state_next = ST_SCAN;
        end else begin
          active_load = 1'b1;
          if (act_found) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = item_addr;
            state_next  = ST_SWEEP_CMP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SWEEP_CMP: begin
        // an empty entry counts as width zero
        if ((hit_valid[item_addr] ? ram_rd_data.width : 12'd0) < item_width[11:0])
          ram_wr_en = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit_valid[idx]) begin
          ram_rd_en  = 1'b1;
          state_next = ST_SCAN_EMIT;
        end else if (idx == IDX_LAST) begin
          state_next = ST_TRACK;
        end else begin
          idx_inc = 1'b1;
        end
      end
      ST_SCAN_EMIT: begin
        if (slot_free) begin
          load_hit = 1'b1;
          if (idx == IDX_LAST) begin
            state_next = ST_TRACK;
          end else begin
            idx_inc    = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_TRACK: begin
        if (slot_free) begin
          load_bit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item capture and decode
  always_ff @(posedge clk) begin
    if (pulse.valid && pulse.ready) begin
      item_time   <= pulse.capture_time;
      item_sensor <= pulse.sensor_index;
      item_width  <= pulse.pulse_width;
    end
    if (state == ST_DECODE) begin
      code <= sync_code(item_width);
      gap  <= $signed(item_time - last_sync_time);
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (idx_clr) idx <= '0;
    else if (idx_inc) idx <= idx + SW'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_window        <= CLUSTER_WINDOW_RST;
      second_emitter_window <= SECOND_WINDOW_RST;
      resync_gap            <= RESYNC_GAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CLUSTER_WINDOW: cluster_window        <= cfg_wdata[19:0];
        REG_SECOND_WINDOW:  second_emitter_window <= cfg_wdata[19:0];
        REG_RESYNC_GAP:     resync_gap            <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hit store valid bits: set on store write, cleared after a sync scan
  always_ff @(posedge clk) begin
    if (rst || load_bit) hit_valid <= '0;
    else if (ram_wr_en) hit_valid[item_addr] <= 1'b1;
  end

  // emitter tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sync_time  <= '0;
      current_emitter <= '0;
      active_valid    <= 1'b0;
      active_idx      <= '0;
      active_start    <= '0;
      active_code     <= '0;
      code_valid      <= '0;
      for (int e = 0; e < EMITTER_COUNT; e++) begin
        emitter_max_width[e]  <= '0;
        emitter_start_time[e] <= '0;
        emitter_code[e]       <= '0;
      end
    end else if (active_load) begin
      active_valid <= act_found;
      active_idx   <= act_idx;
      active_start <= act_start;
      active_code  <= act_code;
    end else if (load_bit) begin
      if (trk_join) begin
        last_sync_time <= item_time;
        if (16'(emitter_max_width[current_emitter]) < item_width) begin
          emitter_start_time[current_emitter] <= item_time;
          emitter_max_width[current_emitter]  <= item_width[12:0];
          emitter_code[current_emitter]       <= code;
          code_valid[current_emitter]         <= 1'b1;
        end
      end else if (trk_second) begin
        active_valid       <= 1'b0;
        last_sync_time     <= item_time;
        current_emitter    <= cur_after;
        emitter_start_time[1] <= item_time;
        emitter_max_width[1]  <= item_width[12:0];
        emitter_code[1]       <= code;
        code_valid[1]         <= 1'b1;
      end else if (trk_resync) begin
        active_valid    <= 1'b0;
        active_start    <= '0;
        active_code     <= '0;
        current_emitter <= cur_after;
        last_sync_time  <= item_time;
        for (int e = 1; e < EMITTER_COUNT; e++) begin
          emitter_max_width[e]  <= '0;
          emitter_start_time[e] <= '0;
          code_valid[e]         <= 1'b0;
        end
        // emitter 0 restarts with this pulse
        emitter_start_time[0] <= item_time;
        emitter_max_width[0]  <= item_width[12:0];
        emitter_code[0]       <= code;
        code_valid[0]         <= 1'b1;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_hit || load_bit) out_valid <= 1'b1;
    else if (result.ready) out_valid <= 1'b0;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_hit) begin
      result.kind        <= 1'b0;
      result.emitter     <= active_valid ? 2'(active_idx) : 2'b11;
      result.axis        <= active_code[0];
      result.sweep_start <= active_start;
      result.hit_sensor  <= 8'(idx);
      result.hit_offset  <= ram_rd_data.stamp - active_start
                            + {21'd0, ram_rd_data.width[11:1]};
      result.hit_width   <= ram_rd_data.width;
      result.data_bit    <= 1'b0;
      result.sync_time   <= '0;
      result.last        <= 1'b0;
    end else if (load_bit) begin
      result.kind        <= 1'b1;
      result.emitter     <= 2'(cur_after);
      result.axis        <= 1'b0;
      result.sweep_start <= '0;
      result.hit_sensor  <= '0;
      result.hit_offset  <= '0;
      result.hit_width   <= '0;
      result.data_bit    <= code[1];
      result.sync_time   <= item_time;
      result.last        <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // the hit store is empty after every sync pulse
  a_store_cleared: assert property (@(posedge clk) disable iff (rst)
    load_bit |=> hit_valid == '0)
    else $error("hit store not cleared after sync");

  // only the data bit beat closes an item
  a_last_on_bit: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.kind == result.last)
    else $error("last flag does not match result kind");

  // hits are stored only under an active emitter
  a_store_needs_active: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> active_valid)
    else $error("hit stored with no active emitter");
`endif

endmodule
